// File: sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared constants, operation codes and the beat and pipeline types of the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_BITS = 32;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int REM_BITS  = PROD_BITS + 1;
    localparam int NUM_BITS  = PROD_BITS + FRAC_BITS;
    localparam int CMP_BITS  = PROD_BITS + WORD_BITS + FRAC_BITS;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic               div_zero;
        logic               overflow;
    } rsp_t;

    typedef struct packed {
        logic                 valid;
        logic                 is_div;
        logic                 b_zero;
        logic                 big_re;
        logic                 big_im;
        logic                 neg_re;
        logic                 neg_im;
        logic [REM_BITS-1:0]  rem_re;
        logic [REM_BITS-1:0]  rem_im;
        logic [WORD_BITS-1:0] q_re;
        logic [WORD_BITS-1:0] q_im;
        logic [WORD_BITS-1:0] num_re;
        logic [WORD_BITS-1:0] num_im;
        logic [PROD_BITS-1:0] den;
    } div_pipe_t;

endpackage

// File: sv/cau_div_step.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider step
// One registered restoring division step for both result parts. Beats that
// are not divides pass through with their magnitudes unchanged.
// ----------------------------------------------------------------------------
module cau_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cau_pkg::div_pipe_t pipe_in,
    output cau_pkg::div_pipe_t pipe_out
);
    import cau_pkg::*;

    div_pipe_t           stage_next;
    div_pipe_t           stage_reg;
    logic                valid_reg;
    logic [REM_BITS-1:0] t_re;
    logic [REM_BITS-1:0] t_im;
    logic [REM_BITS-1:0] d_ext;
    logic                ge_re;
    logic                ge_im;

    always_comb
    begin
        stage_next = pipe_in;
        d_ext      = REM_BITS'(pipe_in.den);
        t_re       = {pipe_in.rem_re[REM_BITS-2:0], pipe_in.num_re[WORD_BITS-1]};
        t_im       = {pipe_in.rem_im[REM_BITS-2:0], pipe_in.num_im[WORD_BITS-1]};
        ge_re      = t_re >= d_ext;
        ge_im      = t_im >= d_ext;
        if (pipe_in.is_div)
        begin
            stage_next.rem_re = ge_re ? (t_re - d_ext) : t_re;
            stage_next.rem_im = ge_im ? (t_im - d_ext) : t_im;
            stage_next.q_re   = {pipe_in.q_re[WORD_BITS-2:0], ge_re};
            stage_next.q_im   = {pipe_in.q_im[WORD_BITS-2:0], ge_im};
            stage_next.num_re = pipe_in.num_re << 1;
            stage_next.num_im = pipe_in.num_im << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= pipe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        pipe_out       = stage_reg;
        pipe_out.valid = valid_reg;
    end

endmodule

// File: sv/complex_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of complex Q16.16 operands with
// saturation and a divide-by-zero flag.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req_data) carries one operation
// and two complex operands per beat. The response channel (rsp_valid,
// rsp_stall, rsp_data) returns one complex result with its flags per beat.
// A beat moves at a rising edge where valid is high and stall is low.
// A beat passes from request to response through one input register,
// one multiplier stage, one sum stage, one magnitude stage, one divider
// setup stage, 32 restoring divider steps (one quotient bit each) and one
// saturation register. Every operation takes the same path, so results
// leave in request order. Throughput is one beat per cycle while req_stall
// is low. When the receiver stalls, the held response moves into a skid
// register and the pipeline advances once more; then req_stall rises and
// the whole pipeline holds until the skid register drains. Reset empties
// the skid register and clears all valid bits, leaving no beat in flight.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cau_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cau_pkg::rsp_t rsp_data
);
    import cau_pkg::*;

    typedef struct packed {
        logic                 ovf;
        logic [WORD_BITS-1:0] val;
    } sat_t;

    localparam logic [REM_BITS-1:0] NEG_LIM = REM_BITS'(1) << (WORD_BITS - 1);
    localparam logic [REM_BITS-1:0] POS_LIM = NEG_LIM - REM_BITS'(1);

    function automatic sat_t saturate(input logic neg, input logic [REM_BITS-1:0] mag);
        sat_t                r;
        logic [REM_BITS-1:0] m;
        r.ovf = 1'b0;
        m     = mag;
        if (!neg)
        begin
            if (mag > POS_LIM)
            begin
                m     = POS_LIM;
                r.ovf = 1'b1;
            end
            r.val = m[WORD_BITS-1:0];
        end
        else
        begin
            if (mag > NEG_LIM)
            begin
                m     = NEG_LIM;
                r.ovf = 1'b1;
            end
            r.val = WORD_BITS'(REM_BITS'(0) - m);
        end
        return r;
    endfunction

    logic en;

    logic                        v1_reg;
    op_t                         s1_op_reg;
    logic signed [WORD_BITS-1:0] s1_ar_reg;
    logic signed [WORD_BITS-1:0] s1_ai_reg;
    logic signed [WORD_BITS-1:0] s1_br_reg;
    logic signed [WORD_BITS-1:0] s1_bi_reg;

    logic                        v2_reg;
    op_t                         s2_op_reg;
    logic                        s2_zero_reg;
    logic signed [PROD_BITS-1:0] s2_rr_reg;
    logic signed [PROD_BITS-1:0] s2_ii_reg;
    logic signed [PROD_BITS-1:0] s2_ri_reg;
    logic signed [PROD_BITS-1:0] s2_ir_reg;
    logic signed [PROD_BITS-1:0] s2_sqr_reg;
    logic signed [PROD_BITS-1:0] s2_sqi_reg;
    logic signed [WORD_BITS:0]   s2_sum_re_reg;
    logic signed [WORD_BITS:0]   s2_sum_im_reg;

    logic                        v3_reg;
    op_t                         s3_op_reg;
    logic                        s3_zero_reg;
    logic signed [REM_BITS-1:0]  s3_v_re_reg;
    logic signed [REM_BITS-1:0]  s3_v_im_reg;
    logic [PROD_BITS-1:0]        s3_den_reg;
    logic signed [REM_BITS-1:0]  s3_v_re_next;
    logic signed [REM_BITS-1:0]  s3_v_im_next;

    logic                        v4_reg;
    op_t                         s4_op_reg;
    logic                        s4_zero_reg;
    logic                        s4_neg_re_reg;
    logic                        s4_neg_im_reg;
    logic [PROD_BITS-1:0]        s4_mag_re_reg;
    logic [PROD_BITS-1:0]        s4_mag_im_reg;
    logic [PROD_BITS-1:0]        s4_den_reg;
    logic [PROD_BITS-1:0]        s4_mag_re_next;
    logic [PROD_BITS-1:0]        s4_mag_im_next;
    logic [REM_BITS-1:0]         abs_re;
    logic [REM_BITS-1:0]         abs_im;

    div_pipe_t                   s5_next;
    div_pipe_t                   s5_reg;
    logic                        v5_reg;
    logic [NUM_BITS-1:0]         n_re;
    logic [NUM_BITS-1:0]         n_im;
    logic [CMP_BITS-1:0]         d_cmp;

    div_pipe_t                   pipe [WORD_BITS+1];

    div_pipe_t                   fin;
    logic [REM_BITS-1:0]         fin_re;
    logic [REM_BITS-1:0]         fin_im;
    sat_t                        sat_re;
    sat_t                        sat_im;
    rsp_t                        out_next;
    rsp_t                        out_reg;
    logic                        out_valid_reg;
    rsp_t                        skid_reg;
    logic                        skid_full_reg;

    assign en        = !skid_full_reg;
    assign req_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg <= op_t'(req_data.req_type);
            s1_ar_reg <= req_data.a_real[WORD_BITS-1:0];
            s1_ai_reg <= req_data.a_imag[WORD_BITS-1:0];
            s1_br_reg <= req_data.b_real[WORD_BITS-1:0];
            s1_bi_reg <= req_data.b_imag[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_zero_reg <= (s1_br_reg == '0) && (s1_bi_reg == '0);
            s2_rr_reg   <= PROD_BITS'(s1_ar_reg) * PROD_BITS'(s1_br_reg);
            s2_ii_reg   <= PROD_BITS'(s1_ai_reg) * PROD_BITS'(s1_bi_reg);
            s2_ri_reg   <= PROD_BITS'(s1_ar_reg) * PROD_BITS'(s1_bi_reg);
            s2_ir_reg   <= PROD_BITS'(s1_ai_reg) * PROD_BITS'(s1_br_reg);
            s2_sqr_reg  <= PROD_BITS'(s1_br_reg) * PROD_BITS'(s1_br_reg);
            s2_sqi_reg  <= PROD_BITS'(s1_bi_reg) * PROD_BITS'(s1_bi_reg);
            if (s1_op_reg == OP_SUB)
            begin
                s2_sum_re_reg <= (WORD_BITS+1)'(s1_ar_reg) - (WORD_BITS+1)'(s1_br_reg);
                s2_sum_im_reg <= (WORD_BITS+1)'(s1_ai_reg) - (WORD_BITS+1)'(s1_bi_reg);
            end
            else
            begin
                s2_sum_re_reg <= (WORD_BITS+1)'(s1_ar_reg) + (WORD_BITS+1)'(s1_br_reg);
                s2_sum_im_reg <= (WORD_BITS+1)'(s1_ai_reg) + (WORD_BITS+1)'(s1_bi_reg);
            end
        end
    end

    always_comb
    begin
        case (s2_op_reg) inside
            OP_ADD, OP_SUB:
            begin
                s3_v_re_next = REM_BITS'(s2_sum_re_reg);
                s3_v_im_next = REM_BITS'(s2_sum_im_reg);
            end
            OP_MUL:
            begin
                s3_v_re_next = REM_BITS'(s2_rr_reg) - REM_BITS'(s2_ii_reg);
                s3_v_im_next = REM_BITS'(s2_ri_reg) + REM_BITS'(s2_ir_reg);
            end
            default:
            begin
                s3_v_re_next = REM_BITS'(s2_rr_reg) + REM_BITS'(s2_ii_reg);
                s3_v_im_next = REM_BITS'(s2_ir_reg) - REM_BITS'(s2_ri_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_v_re_reg <= s3_v_re_next;
            s3_v_im_reg <= s3_v_im_next;
            s3_den_reg  <= $unsigned(s2_sqr_reg) + $unsigned(s2_sqi_reg);
        end
    end

    always_comb
    begin
        abs_re = s3_v_re_reg[REM_BITS-1] ? (REM_BITS'(0) - $unsigned(s3_v_re_reg))
                                         : $unsigned(s3_v_re_reg);
        abs_im = s3_v_im_reg[REM_BITS-1] ? (REM_BITS'(0) - $unsigned(s3_v_im_reg))
                                         : $unsigned(s3_v_im_reg);
        s4_mag_re_next = abs_re[PROD_BITS-1:0];
        s4_mag_im_next = abs_im[PROD_BITS-1:0];
        if (s3_op_reg == OP_MUL)
        begin
            s4_mag_re_next = abs_re[PROD_BITS-1:0] >> FRAC_BITS;
            s4_mag_im_next = abs_im[PROD_BITS-1:0] >> FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_op_reg     <= s3_op_reg;
            s4_zero_reg   <= s3_zero_reg;
            s4_neg_re_reg <= s3_v_re_reg[REM_BITS-1];
            s4_neg_im_reg <= s3_v_im_reg[REM_BITS-1];
            s4_mag_re_reg <= s4_mag_re_next;
            s4_mag_im_reg <= s4_mag_im_next;
            s4_den_reg    <= s3_den_reg;
        end
    end

    always_comb
    begin
        n_re           = NUM_BITS'(s4_mag_re_reg) << FRAC_BITS;
        n_im           = NUM_BITS'(s4_mag_im_reg) << FRAC_BITS;
        d_cmp          = CMP_BITS'(s4_den_reg) << WORD_BITS;
        s5_next.valid  = 1'b0;
        s5_next.is_div = (s4_op_reg == OP_DIV);
        s5_next.b_zero = s4_zero_reg;
        s5_next.big_re = CMP_BITS'(n_re) >= d_cmp;
        s5_next.big_im = CMP_BITS'(n_im) >= d_cmp;
        s5_next.neg_re = s4_neg_re_reg;
        s5_next.neg_im = s4_neg_im_reg;
        s5_next.q_re   = '0;
        s5_next.q_im   = '0;
        s5_next.num_re = n_re[WORD_BITS-1:0];
        s5_next.num_im = n_im[WORD_BITS-1:0];
        s5_next.den    = s4_den_reg;
        if (s4_op_reg == OP_DIV)
        begin
            s5_next.rem_re = REM_BITS'(n_re >> WORD_BITS);
            s5_next.rem_im = REM_BITS'(n_im >> WORD_BITS);
        end
        else
        begin
            s5_next.rem_re = REM_BITS'(s4_mag_re_reg);
            s5_next.rem_im = REM_BITS'(s4_mag_im_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_reg <= s5_next;
        end
    end

    always_comb
    begin
        pipe[0]       = s5_reg;
        pipe[0].valid = v5_reg;
    end

    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_div
        cau_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .pipe_in  (pipe[k]),
            .pipe_out (pipe[k+1])
        );
    end

    always_comb
    begin
        fin    = pipe[WORD_BITS];
        fin_re = fin.rem_re;
        fin_im = fin.rem_im;
        if (fin.is_div)
        begin
            fin_re = fin.big_re ? (REM_BITS'(1) << WORD_BITS) : REM_BITS'(fin.q_re);
            fin_im = fin.big_im ? (REM_BITS'(1) << WORD_BITS) : REM_BITS'(fin.q_im);
        end
        sat_re = saturate(fin.neg_re, fin_re);
        sat_im = saturate(fin.neg_im, fin_im);
        if (fin.is_div && fin.b_zero)
        begin
            out_next.res_real = '0;
            out_next.res_imag = '0;
            out_next.div_zero = 1'b1;
            out_next.overflow = 1'b0;
        end
        else
        begin
            out_next.res_real = FIELD_BITS'($signed(sat_re.val));
            out_next.res_imag = FIELD_BITS'($signed(sat_im.val));
            out_next.div_zero = 1'b0;
            out_next.overflow = sat_re.ovf | sat_im.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                out_valid_reg <= fin.valid;
                if (out_valid_reg && rsp_stall)
                begin
                    skid_full_reg <= 1'b1;
                end
            end
            else if (!rsp_stall)
            begin
                skid_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
            if (out_valid_reg && rsp_stall)
            begin
                skid_reg <= out_reg;
            end
        end
    end

    assign rsp_valid = skid_full_reg || out_valid_reg;
    assign rsp_data  = skid_full_reg ? skid_reg : out_reg;

`ifndef SYNTHESIS
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !rsp_stall |=> !skid_full_reg)
        else $error("skid register did not drain");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(rsp_stall) && $past(out_valid_reg))
        else $error("skid register filled without a stalled beat");

    a_div_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.div_zero |->
            !rsp_data.overflow && rsp_data.res_real == '0 && rsp_data.res_imag == '0)
        else $error("divide by zero beat carries data or overflow");

    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.overflow |->
            rsp_data.res_real == FIELD_BITS'($signed(POS_LIM[WORD_BITS-1:0]))
         || rsp_data.res_real == FIELD_BITS'($signed(NEG_LIM[WORD_BITS-1:0]))
         || rsp_data.res_imag == FIELD_BITS'($signed(POS_LIM[WORD_BITS-1:0]))
         || rsp_data.res_imag == FIELD_BITS'($signed(NEG_LIM[WORD_BITS-1:0])))
        else $error("overflow flagged without a saturated part");
`endif

endmodule

// File: test/tb_complex_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed and random complex operand beats through all four
// operations under random sender gaps and receiver stalls, and checks
// every result beat against an exact fixed point prediction kept in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_top;

    import cau_pkg::*;

    class cau_scoreboard;
        rsp_t pending[$];
        int   errors;
        int   checked;
        int   saturated;
        int   zero_divides;

        function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
            if (v > 128'sd2147483647)
            begin
                ovf = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < -128'sd2147483648)
            begin
                ovf = 1'b1;
                return 32'h8000_0000;
            end
            return v[31:0];
        endfunction

        // Drops fraction bits of a product sum, truncating toward zero.
        function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
            logic [127:0] m;
            m = (v < 0) ? -v : v;
            m = m >> FRAC_BITS;
            return (v < 0) ? -$signed(m) : $signed(m);
        endfunction

        function automatic logic signed [127:0] div_frac(input logic signed [127:0] n,
                                                          input logic [127:0] d);
            logic [127:0] m;
            m = (n < 0) ? -n : n;
            m = (m << FRAC_BITS) / d;
            return (n < 0) ? -$signed(m) : $signed(m);
        endfunction

        function automatic rsp_t complex_result(input req_t r);
            logic signed [127:0] ar, ai, br, bi, re, im;
            logic [127:0]        den;
            logic                ovf;
            rsp_t                o;
            ar = 128'(r.a_real);
            ai = 128'(r.a_imag);
            br = 128'(r.b_real);
            bi = 128'(r.b_imag);
            ovf = 1'b0;
            o = '0;
            case (op_t'(r.req_type))
                OP_ADD:
                begin
                    re = ar + br;
                    im = ai + bi;
                end
                OP_SUB:
                begin
                    re = ar - br;
                    im = ai - bi;
                end
                OP_MUL:
                begin
                    re = trunc_frac(ar * br - ai * bi);
                    im = trunc_frac(ar * bi + ai * br);
                end
                default:
                begin
                    if (br == 0 && bi == 0)
                    begin
                        o.div_zero = 1'b1;
                        return o;
                    end
                    den = br * br + bi * bi;
                    re = div_frac(ar * br + ai * bi, den);
                    im = div_frac(ai * br - ar * bi, den);
                end
            endcase
            o.res_real = clamp(re, ovf);
            o.res_imag = clamp(im, ovf);
            o.overflow = ovf;
            return o;
        endfunction

        function void note(input req_t r);
            pending.push_back(complex_result(r));
        endfunction

        task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
            errors++;
        endtask

        task automatic check(input rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report("unexpected beat", got.res_real, 32'h0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.overflow)
                saturated++;
            if (want.div_zero)
                zero_divides++;
            if (got.res_real !== want.res_real)
                report("res_real", got.res_real, want.res_real);
            if (got.res_imag !== want.res_imag)
                report("res_imag", got.res_imag, want.res_imag);
            if (got.div_zero !== want.div_zero)
                report("div_zero", 32'(got.div_zero), 32'(want.div_zero));
            if (got.overflow !== want.overflow)
                report("overflow", 32'(got.overflow), 32'(want.overflow));
        endtask
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req_data = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp_data;

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    cau_scoreboard results = new();

    complex_arithmetic_unit_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            results.check(rsp_data);
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_beat(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        req_t r;
        r.req_type = op;
        r.a_real = ar;
        r.a_imag = ai;
        r.b_real = br;
        r.b_imag = bi;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        results.note(r);
    endtask

    function automatic logic [31:0] pick_part();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return 32'($signed($urandom_range(8)) - 4) <<< FRAC_BITS;
            3:       return 32'($signed($urandom_range(2000)) - 1000);
            4:       return 32'($signed({$urandom()} % 32'd2000000) - 1000000) <<< 4;
            default: return $urandom_range(3) == 0 ? 32'h0 : 32'($signed($urandom()) >>> 10);
        endcase
    endfunction

    task automatic random_beats(input int count);
        logic [31:0] br, bi;
        for (int i = 0; i < count; i++)
        begin
            br = pick_part();
            bi = pick_part();
            if ($urandom_range(19) == 0)
            begin
                br = 32'h0;
                bi = 32'h0;
            end
            send_beat(op_t'($urandom_range(3)), pick_part(), pick_part(), br, bi);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 22;
        recv_idle_pct = 86;
        for (int k = 0; k < 4; k++)
        begin
            send_beat(op_t'(k), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send_beat(op_t'(k), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_beat(op_t'(k), 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
            send_beat(op_t'(k), 32'h0001_8000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_0001);
        end
        send_beat(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        send_beat(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
        send_beat(OP_DIV, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0000_0001);
        send_beat(OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0);
        send_beat(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
        send_beat(OP_MUL, 32'hFFFF_8000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
        send_beat(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_beat(OP_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
        random_beats(240);
        send_idle_pct = 86;
        recv_idle_pct = 22;
        random_beats(230);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_beats(230);
        req_valid <= 1'b0;
        while (results.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Checked %0d result beats over add, subtract, multiply and divide,",
                 results.checked);
        $display("including %0d saturated results and %0d divides by zero.",
                 results.saturated, results.zero_divides);
        if (results.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d result beats outstanding.", results.pending.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
